FILE: design/assert_macros.svh
// Assertion macros shared by the multiplexer register block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define AMCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define AMCR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: design/amcr_pkg.sv
// Types and constants shared by the multiplexer register block.
package amcr_pkg;

  // Operation codes of an incoming transaction
  localparam logic [2:0] OP_COMMAND  = 3'd0;
  localparam logic [2:0] OP_TRANSMIT = 3'd1;
  localparam logic [2:0] OP_FORMAT   = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_CLR_IRQ  = 3'd4;
  localparam logic [2:0] OP_SKIP     = 3'd5;
  localparam logic [2:0] OP_RX_BYTE  = 3'd6;
  localparam logic [2:0] OP_MODEM    = 3'd7;

  // Command codes in bus word bits 3:0
  localparam logic [3:0] CMD_RX_ON      = 4'h0;
  localparam logic [3:0] CMD_TX_ON      = 4'h2;
  localparam logic [3:0] CMD_TX_OFF     = 4'h3;
  localparam logic [3:0] CMD_LATCH_BUF  = 4'h4;
  localparam logic [3:0] CMD_LATCH_MDM  = 4'h5;
  localparam logic [3:0] CMD_LATCH_OUT  = 4'h7;
  localparam logic [3:0] CMD_DTR_ON     = 4'h8;
  localparam logic [3:0] CMD_DTR_OFF    = 4'h9;

  // Format selectors in bus word bits 5:4
  localparam logic [1:0] FMT_LINE0   = 2'd0;
  localparam logic [1:0] FMT_LINE1   = 2'd1;
  localparam logic [1:0] FMT_RX_BAUD = 2'd2;
  localparam logic [1:0] FMT_TX_BAUD = 2'd3;

  // Skip test kinds
  localparam logic [1:0] SKIP_BUSY_NZ = 2'd0;
  localparam logic [1:0] SKIP_BUSY_Z  = 2'd1;
  localparam logic [1:0] SKIP_DONE_NZ = 2'd2;
  localparam logic [1:0] SKIP_DONE_Z  = 2'd3;

  // Parity codes
  localparam logic [1:0] PAR_ODD  = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_NONE = 2'd2;

  // Fixed words
  localparam logic [15:0] BUF_EMPTY_WORD  = 16'h0080;
  localparam logic [15:0] OUT_STATUS_WORD = 16'hC000;
  localparam logic [2:0]  MODEM_CH0_RESET = 3'b110;

  // Queue between decode and execute
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified action of one transaction
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_RX_MODE,
    ACT_TX_ON,
    ACT_TX_OFF,
    ACT_LATCH_BUF,
    ACT_LATCH_MODEM,
    ACT_LATCH_OUT,
    ACT_DTR_ON,
    ACT_DTR_OFF,
    ACT_BAD_CMD,
    ACT_TRANSMIT,
    ACT_FMT_LINE,
    ACT_FMT_RX_BAUD,
    ACT_FMT_TX_BAUD,
    ACT_READ,
    ACT_CLR_IRQ,
    ACT_SKIP,
    ACT_SKIP_BAD,
    ACT_RX_BYTE,
    ACT_MODEM
  } act_t;

  // Decoded transaction handed from front to back
  typedef struct packed {
    act_t       act;
    logic [2:0] ch;
    logic       ok;
    logic [7:0] data;
  } dec_t;

endpackage

FILE: design/async_mux_channel_registers.sv
// Top level of the multiplexer register block: front, queue and back.
//
//  Channel   Handshake             Payload
//  input     in_valid / in_ready   op, bus_word, skip_kind, line_channel, rx_byte,
//                                  ring, carrier, set_ready
//  result    out_valid / out_ready read_data, tx_valid, tx_channel, tx_byte, skip,
//                                  irq_request, error, dtr_level, tx_enabled
//
//  One transaction per cycle is sustained while out_ready stays high; each accepted
//  transaction is written into the queue, then popped from it and executed into the
//  result register, from which it can be taken.
//  Execution of one transaction per cycle is set by the single state update port.
//  Reset clears all channel state; channel 0 modem lines read
//  carrier and ready.
//  When out_ready is low the result register holds and the two-entry queue fills;
//  in_ready drops only once the queue is full.
module async_mux_channel_registers #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [15:0] bus_word,
  input  logic [1:0]  skip_kind,
  input  logic [2:0]  line_channel,
  input  logic [7:0]  rx_byte,
  input  logic        ring,
  input  logic        carrier,
  input  logic        set_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] read_data,
  output logic        tx_valid,
  output logic [2:0]  tx_channel,
  output logic [7:0]  tx_byte,
  output logic        skip,
  output logic        irq_request,
  output logic        error,
  output logic        dtr_level,
  output logic        tx_enabled
);

  amcr_pkg::dec_t dec;
  amcr_pkg::dec_t head_data;
  logic           full;
  logic           head_valid;
  logic           pop;
  logic           push;

  assign in_ready = !full;
  assign push     = in_valid && in_ready;

  // Classify incoming transactions
  amcr_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .op           (op),
    .bus_word     (bus_word),
    .skip_kind    (skip_kind),
    .line_channel (line_channel),
    .rx_byte      (rx_byte),
    .ring         (ring),
    .carrier      (carrier),
    .set_ready    (set_ready),
    .dec          (dec)
  );

  // Buffer decoded transactions
  amcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (dec),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Execute and register results
  amcr_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .tx_valid    (tx_valid),
    .tx_channel  (tx_channel),
    .tx_byte     (tx_byte),
    .skip        (skip),
    .irq_request (irq_request),
    .error       (error),
    .dtr_level   (dtr_level),
    .tx_enabled  (tx_enabled)
  );

endmodule

FILE: design/amcr_front.sv
// Front end: classify each incoming transaction into a decoded action.
module amcr_front #(
  parameter int CHANNELS = 8
) (
  input  logic [2:0]       op,
  input  logic [15:0]      bus_word,
  input  logic [1:0]       skip_kind,
  input  logic [2:0]       line_channel,
  input  logic [7:0]       rx_byte,
  input  logic             ring,
  input  logic             carrier,
  input  logic             set_ready,
  output amcr_pkg::dec_t   dec
);

  localparam logic [3:0] CH_LIMIT = 4'(CHANNELS);

  logic [2:0] ch;
  logic       ok;

  // Pick the addressed channel and check it against the channel count
  assign ch = (op == amcr_pkg::OP_RX_BYTE || op == amcr_pkg::OP_MODEM) ?
              line_channel : bus_word[10:8];
  assign ok = ({1'b0, ch} < CH_LIMIT);

  // Classify the transaction
  always_comb begin
    dec.ch   = ch;
    dec.ok   = ok;
    dec.data = 8'd0;
    dec.act  = amcr_pkg::ACT_NONE;
    case (op)
      amcr_pkg::OP_COMMAND: begin
        if (ok) begin
          case (bus_word[3:0])
            amcr_pkg::CMD_RX_ON:     dec.act = amcr_pkg::ACT_RX_MODE;
            amcr_pkg::CMD_TX_ON:     dec.act = amcr_pkg::ACT_TX_ON;
            amcr_pkg::CMD_TX_OFF:    dec.act = amcr_pkg::ACT_TX_OFF;
            amcr_pkg::CMD_LATCH_BUF: dec.act = amcr_pkg::ACT_LATCH_BUF;
            amcr_pkg::CMD_LATCH_MDM: dec.act = amcr_pkg::ACT_LATCH_MODEM;
            amcr_pkg::CMD_LATCH_OUT: dec.act = amcr_pkg::ACT_LATCH_OUT;
            amcr_pkg::CMD_DTR_ON:    dec.act = amcr_pkg::ACT_DTR_ON;
            amcr_pkg::CMD_DTR_OFF:   dec.act = amcr_pkg::ACT_DTR_OFF;
            default:                 dec.act = amcr_pkg::ACT_BAD_CMD;
          endcase
        end
      end
      amcr_pkg::OP_TRANSMIT: begin
        if (ok) begin
          dec.act  = amcr_pkg::ACT_TRANSMIT;
          dec.data = bus_word[7:0];
        end
      end
      amcr_pkg::OP_FORMAT: begin
        if (ok) begin
          case (bus_word[5:4])
            amcr_pkg::FMT_LINE0,
            amcr_pkg::FMT_LINE1: begin
              dec.act  = amcr_pkg::ACT_FMT_LINE;
              dec.data = {2'b00, bus_word[5:0]};
            end
            amcr_pkg::FMT_RX_BAUD: begin
              dec.act  = amcr_pkg::ACT_FMT_RX_BAUD;
              dec.data = {4'd0, bus_word[3:0]};
            end
            default: begin
              dec.act  = amcr_pkg::ACT_FMT_TX_BAUD;
              dec.data = {4'd0, bus_word[3:0]};
            end
          endcase
        end
      end
      amcr_pkg::OP_READ:    dec.act = amcr_pkg::ACT_READ;
      amcr_pkg::OP_CLR_IRQ: dec.act = amcr_pkg::ACT_CLR_IRQ;
      amcr_pkg::OP_SKIP: begin
        case (skip_kind)
          amcr_pkg::SKIP_BUSY_Z,
          amcr_pkg::SKIP_DONE_NZ: dec.act = amcr_pkg::ACT_SKIP;
          amcr_pkg::SKIP_DONE_Z:  dec.act = amcr_pkg::ACT_SKIP_BAD;
          default:                dec.act = amcr_pkg::ACT_NONE;
        endcase
      end
      amcr_pkg::OP_RX_BYTE: begin
        if (ok) begin
          dec.act  = amcr_pkg::ACT_RX_BYTE;
          dec.data = rx_byte;
        end
      end
      default: begin
        if (ok) begin
          dec.act  = amcr_pkg::ACT_MODEM;
          dec.data = {5'd0, set_ready, carrier, ring};
        end
      end
    endcase
  end

endmodule

FILE: design/amcr_queue.sv
// Short queue of decoded transactions between front and back.
module amcr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  amcr_pkg::dec_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output amcr_pkg::dec_t head_data
);

  amcr_pkg::dec_t                 slots [amcr_pkg::QUEUE_DEPTH];
  logic [amcr_pkg::QPTR_W-1:0]    wr_ptr;
  logic [amcr_pkg::QPTR_W-1:0]    rd_ptr;
  logic [amcr_pkg::QCNT_W-1:0]    count;

  assign full       = (count == amcr_pkg::QCNT_W'(amcr_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

FILE: design/amcr_back.sv
// Back end: per-channel state, execution of decoded actions, result register.
`include "assert_macros.svh"
module amcr_back #(
  parameter int CHANNELS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  amcr_pkg::dec_t head_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    read_data,
  output logic           tx_valid,
  output logic [2:0]     tx_channel,
  output logic [7:0]     tx_byte,
  output logic           skip,
  output logic           irq_request,
  output logic           error,
  output logic           dtr_level,
  output logic           tx_enabled
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Per-channel state
  logic [15:0] input_buffer   [CHANNELS];
  logic        receive_mode   [CHANNELS];
  logic        transmit_mode  [CHANNELS];
  logic        terminal_ready [CHANNELS];
  logic [2:0]  modem_lines    [CHANNELS];
  logic [1:0]  data_bits_code [CHANNELS];
  logic        two_stop_bits  [CHANNELS];
  logic [1:0]  parity_mode    [CHANNELS];
  logic [3:0]  rx_baud_index  [CHANNELS];
  logic [3:0]  tx_baud_index  [CHANNELS];
  logic [15:0] read_latch;
  logic        irq_pending;

  amcr_pkg::act_t  act;
  logic [CH_W-1:0] ci;
  logic            ok;
  logic [7:0]      data;
  logic [2:0]      mdm;
  logic [15:0]     modem_word;
  logic [1:0]      parity_next;
  logic            irq_next;
  logic            dtr_next;
  logic            txen_next;

  assign act  = head_data.act;
  assign ci   = head_data.ch[CH_W-1:0];
  assign ok   = head_data.ok;
  assign data = head_data.data;
  assign pop  = head_valid && (!out_valid || out_ready);

  // Build modem status word and line parity
  assign mdm         = modem_lines[ci];
  assign modem_word  = {mdm[0], ~mdm[1], ~mdm[2], 13'd0};
  assign parity_next = (data[3:2] == 2'd0) ? amcr_pkg::PAR_ODD :
                       (data[3:2] == 2'd1) ? amcr_pkg::PAR_EVEN : amcr_pkg::PAR_NONE;

  // Work out levels after this transaction
  always_comb begin
    irq_next = irq_pending;
    if (act == amcr_pkg::ACT_CLR_IRQ)      irq_next = 1'b0;
    else if (act == amcr_pkg::ACT_RX_BYTE) irq_next = 1'b1;

    dtr_next = 1'b0;
    txen_next = 1'b0;
    if (ok) begin
      dtr_next  = terminal_ready[ci];
      txen_next = transmit_mode[ci];
      if (act == amcr_pkg::ACT_DTR_ON)       dtr_next  = 1'b1;
      else if (act == amcr_pkg::ACT_DTR_OFF) dtr_next  = 1'b0;
      if (act == amcr_pkg::ACT_TX_ON)        txen_next = 1'b1;
      else if (act == amcr_pkg::ACT_TX_OFF)  txen_next = 1'b0;
    end
  end

  // Update channel state on each executed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        input_buffer[i]   <= '0;
        receive_mode[i]   <= 1'b0;
        transmit_mode[i]  <= 1'b0;
        terminal_ready[i] <= 1'b0;
        modem_lines[i]    <= (i == 0) ? amcr_pkg::MODEM_CH0_RESET : 3'b000;
        data_bits_code[i] <= '0;
        two_stop_bits[i]  <= 1'b0;
        parity_mode[i]    <= amcr_pkg::PAR_ODD;
        rx_baud_index[i]  <= '0;
        tx_baud_index[i]  <= '0;
      end
      read_latch     <= '0;
      irq_pending    <= 1'b0;
    end else if (pop) begin
      irq_pending <= irq_next;
      case (act)
        amcr_pkg::ACT_RX_MODE:     receive_mode[ci]   <= 1'b1;
        amcr_pkg::ACT_TX_ON:       transmit_mode[ci]  <= 1'b1;
        amcr_pkg::ACT_TX_OFF:      transmit_mode[ci]  <= 1'b0;
        amcr_pkg::ACT_DTR_ON:      terminal_ready[ci] <= 1'b1;
        amcr_pkg::ACT_DTR_OFF:     terminal_ready[ci] <= 1'b0;
        amcr_pkg::ACT_LATCH_BUF: begin
          read_latch       <= input_buffer[ci];
          input_buffer[ci] <= amcr_pkg::BUF_EMPTY_WORD;
        end
        amcr_pkg::ACT_LATCH_MODEM: read_latch <= modem_word;
        amcr_pkg::ACT_LATCH_OUT:   read_latch <= amcr_pkg::OUT_STATUS_WORD;
        amcr_pkg::ACT_FMT_LINE: begin
          two_stop_bits[ci]  <= data[4];
          data_bits_code[ci] <= data[1:0];
          parity_mode[ci]    <= parity_next;
        end
        amcr_pkg::ACT_FMT_RX_BAUD: rx_baud_index[ci] <= data[3:0];
        amcr_pkg::ACT_FMT_TX_BAUD: tx_baud_index[ci] <= data[3:0];
        amcr_pkg::ACT_RX_BYTE:     input_buffer[ci]  <= {8'h80, data};
        amcr_pkg::ACT_MODEM:       modem_lines[ci]   <= data[2:0];
        default: ;
      endcase
    end
  end

  // Hold the result until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pop || (out_valid && !out_ready);
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      read_data   <= (act == amcr_pkg::ACT_READ) ? read_latch : 16'd0;
      tx_valid    <= (act == amcr_pkg::ACT_TRANSMIT);
      tx_channel  <= (act == amcr_pkg::ACT_TRANSMIT) ? head_data.ch : 3'd0;
      tx_byte     <= (act == amcr_pkg::ACT_TRANSMIT) ? data : 8'd0;
      skip        <= (act == amcr_pkg::ACT_SKIP);
      irq_request <= irq_next;
      error       <= (act == amcr_pkg::ACT_BAD_CMD) || (act == amcr_pkg::ACT_SKIP_BAD);
      dtr_level   <= dtr_next;
      tx_enabled  <= txen_next;
    end
  end

  `AMCR_ASSERT(a_tx_alone, out_valid && tx_valid |-> !error && !skip && read_data == 16'd0, "transmit result carries other flags")
  `AMCR_ASSERT(a_clr_irq, pop && act == amcr_pkg::ACT_CLR_IRQ |=> !irq_pending && !irq_request, "interrupt not cleared")
  `AMCR_ASSERT(a_rx_irq, pop && act == amcr_pkg::ACT_RX_BYTE |=> irq_pending && irq_request, "received byte raised no interrupt")
  `AMCR_ASSERT(a_latch_hold, !(pop && (act == amcr_pkg::ACT_LATCH_BUF || act == amcr_pkg::ACT_LATCH_MODEM || act == amcr_pkg::ACT_LATCH_OUT)) |=> $stable(read_latch), "read latch changed without a latch command")

endmodule

FILE: tb/sv/tb_async_mux_channel_registers.sv
// Testbench for the multiplexer register block: directed table, random traffic, scoreboard.
module tb_async_mux_channel_registers;

  localparam int CHANNELS       = 8;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] bus_word;
    logic [1:0]  skip_kind;
    logic [2:0]  line_channel;
    logic [7:0]  rx_byte;
    logic        ring;
    logic        carrier;
    logic        set_ready;
  } access_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [2:0]  tx_channel;
    logic [7:0]  tx_byte;
    logic        skip;
    logic        irq_request;
    logic        error;
    logic        dtr_level;
    logic        tx_enabled;
  } response_t;

  typedef struct packed {
    access_t   acc;
    logic      typed;
    response_t rsp;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  op;
  logic [15:0] bus_word;
  logic [1:0]  skip_kind;
  logic [2:0]  line_channel;
  logic [7:0]  rx_byte;
  logic        ring;
  logic        carrier;
  logic        set_ready;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] read_data;
  logic        tx_valid;
  logic [2:0]  tx_channel;
  logic [7:0]  tx_byte;
  logic        skip;
  logic        irq_request;
  logic        error;
  logic        dtr_level;
  logic        tx_enabled;

  // Shadow copy of the per-channel register file
  logic [15:0] line_buf   [8];
  logic        rcv_on     [8];
  logic        xmt_on     [8];
  logic        dtr_on     [8];
  logic [2:0]  mdm_lines  [8];
  logic [1:0]  fmt_bits   [8];
  logic        fmt_stop2  [8];
  logic [1:0]  fmt_parity [8];
  logic [3:0]  baud_rx    [8];
  logic [3:0]  baud_tx    [8];
  logic [15:0] held_word;
  logic        irq_set;

  response_t   pending_responses[$];
  dir_row_t    directed_rows[$];
  response_t   want;
  int          fail_count;
  bit          no_idle;

  async_mux_channel_registers #(.CHANNELS(CHANNELS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .bus_word     (bus_word),
    .skip_kind    (skip_kind),
    .line_channel (line_channel),
    .rx_byte      (rx_byte),
    .ring         (ring),
    .carrier      (carrier),
    .set_ready    (set_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .tx_valid     (tx_valid),
    .tx_channel   (tx_channel),
    .tx_byte      (tx_byte),
    .skip         (skip),
    .irq_request  (irq_request),
    .error        (error),
    .dtr_level    (dtr_level),
    .tx_enabled   (tx_enabled)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one transaction to the shadow registers and return its response
  function automatic response_t mux_access(input access_t a);
    logic [2:0] ch;
    logic       ok;
    logic [1:0] par;
    response_t  r;
    r  = '0;
    ch = (a.op == amcr_pkg::OP_RX_BYTE || a.op == amcr_pkg::OP_MODEM) ?
         a.line_channel : a.bus_word[10:8];
    ok = (int'(ch) < CHANNELS);
    case (a.op)
      amcr_pkg::OP_COMMAND: begin
        if (ok) begin
          case (a.bus_word[3:0])
            amcr_pkg::CMD_RX_ON:     rcv_on[ch] = 1'b1;
            amcr_pkg::CMD_TX_ON:     xmt_on[ch] = 1'b1;
            amcr_pkg::CMD_TX_OFF:    xmt_on[ch] = 1'b0;
            amcr_pkg::CMD_LATCH_BUF: begin
              held_word    = line_buf[ch];
              line_buf[ch] = amcr_pkg::BUF_EMPTY_WORD;
            end
            amcr_pkg::CMD_LATCH_MDM: held_word = {mdm_lines[ch][0], ~mdm_lines[ch][1],
                                                  ~mdm_lines[ch][2], 13'b0};
            amcr_pkg::CMD_LATCH_OUT: held_word = amcr_pkg::OUT_STATUS_WORD;
            amcr_pkg::CMD_DTR_ON:    dtr_on[ch] = 1'b1;
            amcr_pkg::CMD_DTR_OFF:   dtr_on[ch] = 1'b0;
            default:                 r.error = 1'b1;
          endcase
        end
      end
      amcr_pkg::OP_TRANSMIT: begin
        if (ok) begin
          r.tx_valid   = 1'b1;
          r.tx_channel = ch;
          r.tx_byte    = a.bus_word[7:0];
        end
      end
      amcr_pkg::OP_FORMAT: begin
        if (ok) begin
          case (a.bus_word[5:4])
            amcr_pkg::FMT_LINE0, amcr_pkg::FMT_LINE1: begin
              fmt_stop2[ch] = a.bus_word[4];
              fmt_bits[ch]  = a.bus_word[1:0];
              par = a.bus_word[3:2];
              fmt_parity[ch] = (par == 2'd0) ? amcr_pkg::PAR_ODD :
                               ((par == 2'd1) ? amcr_pkg::PAR_EVEN : amcr_pkg::PAR_NONE);
            end
            amcr_pkg::FMT_RX_BAUD: baud_rx[ch] = a.bus_word[3:0];
            default:               baud_tx[ch] = a.bus_word[3:0];
          endcase
        end
      end
      amcr_pkg::OP_READ:    r.read_data = held_word;
      amcr_pkg::OP_CLR_IRQ: irq_set = 1'b0;
      amcr_pkg::OP_SKIP: begin
        case (a.skip_kind)
          amcr_pkg::SKIP_BUSY_Z, amcr_pkg::SKIP_DONE_NZ: r.skip = 1'b1;
          amcr_pkg::SKIP_DONE_Z:                         r.error = 1'b1;
          default:                                       r.skip = 1'b0;
        endcase
      end
      amcr_pkg::OP_RX_BYTE: begin
        if (ok) begin
          line_buf[ch] = {8'h80, a.rx_byte};
          irq_set      = 1'b1;
        end
      end
      default: begin
        if (ok) mdm_lines[ch] = {a.set_ready, a.carrier, a.ring};
      end
    endcase
    r.irq_request = irq_set;
    r.dtr_level   = ok ? dtr_on[ch] : 1'b0;
    r.tx_enabled  = ok ? xmt_on[ch] : 1'b0;
    return r;
  endfunction

  // Build a table row; typed rows carry a response with only read data, skip and error set
  function automatic dir_row_t row(input logic [2:0] o, input logic [15:0] w,
                                   input logic [1:0] k, input logic [2:0] lch,
                                   input logic [7:0] rxb, input logic [2:0] lines,
                                   input logic typed, input logic [15:0] rd,
                                   input logic skp, input logic err);
    dir_row_t d;
    d = '0;
    d.acc.op           = o;
    d.acc.bus_word     = w;
    d.acc.skip_kind    = k;
    d.acc.line_channel = lch;
    d.acc.rx_byte      = rxb;
    d.acc.ring         = lines[0];
    d.acc.carrier      = lines[1];
    d.acc.set_ready    = lines[2];
    d.typed            = typed;
    d.rsp.read_data    = rd;
    d.rsp.skip         = skp;
    d.rsp.error        = err;
    return d;
  endfunction

  function automatic access_t random_access();
    access_t a;
    a.op           = 3'($urandom_range(0, 7));
    a.bus_word     = 16'($urandom_range(0, 65535));
    a.skip_kind    = 2'($urandom_range(0, 3));
    a.line_channel = 3'($urandom_range(0, 7));
    a.rx_byte      = 8'($urandom_range(0, 255));
    a.ring         = 1'($urandom_range(0, 1));
    a.carrier      = 1'($urandom_range(0, 1));
    a.set_ready    = 1'($urandom_range(0, 1));
    return a;
  endfunction

  // Mostly known command codes, sometimes any code including unknown ones
  function automatic logic [3:0] pick_command();
    logic [3:0] c;
    case ($urandom_range(0, 9))
      0:       c = amcr_pkg::CMD_RX_ON;
      1:       c = amcr_pkg::CMD_TX_ON;
      2:       c = amcr_pkg::CMD_TX_OFF;
      3:       c = amcr_pkg::CMD_LATCH_BUF;
      4:       c = amcr_pkg::CMD_LATCH_MDM;
      5:       c = amcr_pkg::CMD_LATCH_OUT;
      6:       c = amcr_pkg::CMD_DTR_ON;
      7:       c = amcr_pkg::CMD_DTR_OFF;
      default: c = 4'($urandom_range(0, 15));
    endcase
    return c;
  endfunction

  // Drive one transaction after a random gap and record its expected response
  task automatic send_access(input access_t a, input logic typed, input response_t rsp);
    int        gap;
    response_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= a.op;
    bus_word     <= a.bus_word;
    skip_kind    <= a.skip_kind;
    line_channel <= a.line_channel;
    rx_byte      <= a.rx_byte;
    ring         <= a.ring;
    carrier      <= a.carrier;
    set_ready    <= a.set_ready;
    do @(posedge clk); while (!in_ready);
    predicted = mux_access(a);
    pending_responses.push_back(typed ? rsp : predicted);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Main sequence: reset, directed table, random traffic, drain
  initial begin
    access_t    a;
    int         sent;
    int         pick;
    logic [2:0] ch;
    fail_count   = 0;
    no_idle      = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = '0;
    bus_word     = '0;
    skip_kind    = '0;
    line_channel = '0;
    rx_byte      = '0;
    ring         = 1'b0;
    carrier      = 1'b0;
    set_ready    = 1'b0;
    for (int i = 0; i < 8; i++) begin
      line_buf[i]   = '0;
      rcv_on[i]     = 1'b0;
      xmt_on[i]     = 1'b0;
      dtr_on[i]     = 1'b0;
      mdm_lines[i]  = '0;
      fmt_bits[i]   = '0;
      fmt_stop2[i]  = 1'b0;
      fmt_parity[i] = amcr_pkg::PAR_ODD;
      baud_rx[i]    = '0;
      baud_tx[i]    = '0;
    end
    mdm_lines[0] = amcr_pkg::MODEM_CH0_RESET;
    held_word    = '0;
    irq_set      = 1'b0;

    // Reset state, latches, extremes and error codes
    directed_rows.push_back(row(amcr_pkg::OP_READ, 16'h0000, amcr_pkg::SKIP_BUSY_NZ, 3'd0,
                                8'h00, 3'b000, 1'b1, 16'h0000, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND,
                                {13'h00E0, 3'b000} | amcr_pkg::CMD_LATCH_MDM,
                                amcr_pkg::SKIP_DONE_Z, 3'd7, 8'hFF, 3'b111,
                                1'b1, 16'h0000, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_READ, 16'h0700, amcr_pkg::SKIP_BUSY_NZ, 3'd0,
                                8'h00, 3'b000, 1'b1, 16'h6000, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'hF800 | amcr_pkg::CMD_LATCH_OUT,
                                amcr_pkg::SKIP_BUSY_NZ, 3'd0, 8'h00, 3'b000,
                                1'b1, 16'h0000, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_READ, 16'hFFFF, amcr_pkg::SKIP_DONE_Z, 3'd7,
                                8'hFF, 3'b111, 1'b1, amcr_pkg::OUT_STATUS_WORD, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'h060F, amcr_pkg::SKIP_BUSY_NZ, 3'd0,
                                8'h00, 3'b000, 1'b1, 16'h0000, 1'b0, 1'b1));
    directed_rows.push_back(row(amcr_pkg::OP_SKIP, 16'h0000, amcr_pkg::SKIP_BUSY_NZ, 3'd0,
                                8'h00, 3'b000, 1'b1, 16'h0000, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_SKIP, 16'h0000, amcr_pkg::SKIP_BUSY_Z, 3'd0,
                                8'h00, 3'b000, 1'b1, 16'h0000, 1'b1, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_SKIP, 16'hFFFF, amcr_pkg::SKIP_DONE_NZ, 3'd7,
                                8'hFF, 3'b111, 1'b1, 16'h0000, 1'b1, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_SKIP, 16'h0000, amcr_pkg::SKIP_DONE_Z, 3'd0,
                                8'h00, 3'b000, 1'b1, 16'h0000, 1'b0, 1'b1));
    directed_rows.push_back(row(amcr_pkg::OP_FORMAT, 16'h003F, amcr_pkg::SKIP_BUSY_NZ, 3'd0,
                                8'h00, 3'b000, 1'b1, 16'h0000, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_FORMAT, 16'h0714, amcr_pkg::SKIP_BUSY_NZ, 3'd0,
                                8'h00, 3'b000, 1'b1, 16'h0000, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_MODEM, 16'hFFFF, amcr_pkg::SKIP_BUSY_NZ, 3'd0,
                                8'h00, 3'b001, 1'b1, 16'h0000, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'h0000 | amcr_pkg::CMD_LATCH_MDM,
                                amcr_pkg::SKIP_BUSY_NZ, 3'd0, 8'h00, 3'b000,
                                1'b1, 16'h0000, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_READ, 16'h0000, amcr_pkg::SKIP_BUSY_NZ, 3'd0,
                                8'h00, 3'b000, 1'b1, 16'hE000, 1'b0, 1'b0));
    // Mode, DTR, transmit and receive-buffer rows checked against the predictor
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'h0300 | amcr_pkg::CMD_TX_ON, 2'd0,
                                3'd0, 8'h00, 3'b000, 1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'h0300 | amcr_pkg::CMD_DTR_ON, 2'd0,
                                3'd0, 8'h00, 3'b000, 1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_TRANSMIT, 16'h03FF, 2'd0, 3'd0, 8'h00, 3'b000,
                                1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_TRANSMIT, 16'hFF00, 2'd0, 3'd0, 8'h00, 3'b000,
                                1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'h0300 | amcr_pkg::CMD_DTR_OFF, 2'd0,
                                3'd0, 8'h00, 3'b000, 1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'h0300 | amcr_pkg::CMD_TX_OFF, 2'd0,
                                3'd0, 8'h00, 3'b000, 1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_RX_BYTE, 16'h0000, 2'd0, 3'd7, 8'hFF, 3'b000,
                                1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'h0700 | amcr_pkg::CMD_LATCH_BUF,
                                2'd0, 3'd0, 8'h00, 3'b000, 1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_READ, 16'h0000, 2'd0, 3'd0, 8'h00, 3'b000,
                                1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'h0700 | amcr_pkg::CMD_LATCH_BUF,
                                2'd0, 3'd0, 8'h00, 3'b000, 1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_READ, 16'h0000, 2'd0, 3'd0, 8'h00, 3'b000,
                                1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_CLR_IRQ, 16'h0000, 2'd0, 3'd0, 8'h00, 3'b000,
                                1'b0, 16'h0, 1'b0, 1'b0));
    directed_rows.push_back(row(amcr_pkg::OP_COMMAND, 16'h0500 | amcr_pkg::CMD_RX_ON, 2'd0,
                                3'd0, 8'h00, 3'b000, 1'b0, 16'h0, 1'b0, 1'b0));

    // Hold reset, then release it
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_rows[i])
      send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].rsp);

    // Random traffic: mostly buffer, modem and transmit sequences, the rest noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) == 0) no_idle = ~no_idle;
      a    = random_access();
      ch   = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        if (a.op == amcr_pkg::OP_COMMAND) a.bus_word[3:0] = pick_command();
        send_access(a, 1'b0, '0);
        sent += 1;
      end else if (pick < 8) begin
        a.op           = (pick < 6) ? amcr_pkg::OP_RX_BYTE : amcr_pkg::OP_MODEM;
        a.line_channel = ch;
        send_access(a, 1'b0, '0);
        a = random_access();
        a.op             = amcr_pkg::OP_COMMAND;
        a.bus_word[10:8] = ch;
        a.bus_word[3:0]  = (pick < 6) ? amcr_pkg::CMD_LATCH_BUF : amcr_pkg::CMD_LATCH_MDM;
        send_access(a, 1'b0, '0);
        a = random_access();
        a.op = amcr_pkg::OP_READ;
        send_access(a, 1'b0, '0);
        sent += 3;
      end else begin
        a.op             = amcr_pkg::OP_COMMAND;
        a.bus_word[10:8] = ch;
        case ($urandom_range(0, 3))
          0:       a.bus_word[3:0] = amcr_pkg::CMD_TX_ON;
          1:       a.bus_word[3:0] = amcr_pkg::CMD_TX_OFF;
          2:       a.bus_word[3:0] = amcr_pkg::CMD_DTR_ON;
          default: a.bus_word[3:0] = amcr_pkg::CMD_DTR_OFF;
        endcase
        send_access(a, 1'b0, '0);
        a = random_access();
        a.op             = amcr_pkg::OP_TRANSMIT;
        a.bus_word[10:8] = ch;
        send_access(a, 1'b0, '0);
        sent += 2;
      end
    end

    // Drain outstanding responses, then watch for stray ones
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("async_mux_channel_registers regression: pass");
    else
      $display("async_mux_channel_registers regression: fail");
    $finish;
  end

  // Result side: stall a random number of cycles before each transaction
  initial begin
    int stall;
    out_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual read_data %h tx_valid %b",
                 $time, read_data, tx_valid);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("read_data",   want.read_data,        read_data);
        check_field("tx_valid",    16'(want.tx_valid),    16'(tx_valid));
        check_field("tx_channel",  16'(want.tx_channel),  16'(tx_channel));
        check_field("tx_byte",     16'(want.tx_byte),     16'(tx_byte));
        check_field("skip",        16'(want.skip),        16'(skip));
        check_field("irq_request", 16'(want.irq_request), 16'(irq_request));
        check_field("error",       16'(want.error),       16'(error));
        check_field("dtr_level",   16'(want.dtr_level),   16'(dtr_level));
        check_field("tx_enabled",  16'(want.tx_enabled),  16'(tx_enabled));
      end
    end
  end

  // Abort when neither channel moves a transaction for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog expired with %0d results outstanding", $time,
             pending_responses.size());
    $display("async_mux_channel_registers regression: fail");
    $finish;
  end

endmodule
